### hdl/htw_pkg.sv
// shared types, codes and widths for the hashed timer wheel
// no dependencies; imported by htw_cell and hashed_timer_wheel_top
package htw_pkg;

    localparam int CMD_W     = 2;
    localparam int TIMEOUT_W = 16;
    localparam int HANDLE_W  = 5;
    localparam int TAG_W     = 16;
    localparam int KIND_W    = 3;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    localparam int SLOTS_DEF  = 64;
    localparam int TIMERS_DEF = 32;
    localparam int MAX_OUT    = 32;

    localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

    localparam logic [KIND_W-1:0] KIND_REGISTERED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REG_FAILED  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CANCEL_FAIL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXPIRED     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TICK_NONE   = 3'd5;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic alloc;
        logic cancel;
        logic tok_load;
        logic step;
        logic room;
    } htw_ctrl_t;

    // status from one cell back to the sequencer
    typedef struct packed {
        logic hit;
        logic take;
        logic cancel_hit;
    } htw_stat_t;

endpackage

### hdl/htw_cell.sv
// one timer entry of the wheel: valid bit, slot, rotation count and tag
// depends on htw_pkg; instantiated in a chain by hashed_timer_wheel_top
module htw_cell
    import htw_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int SLOT_W = 6,
    parameter int ROT_W  = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  htw_ctrl_t           ctrl,
    input  logic [SLOT_W-1:0]   cur_slot,
    input  logic [SLOT_W-1:0]   new_slot,
    input  logic [ROT_W-1:0]    new_rot,
    input  logic [TAG_W-1:0]    new_tag,
    input  logic [HANDLE_W-1:0] handle,
    input  logic                free_in,
    output logic                free_out,
    input  logic                token_in,
    output logic                token_out,
    output htw_stat_t           stat,
    output logic [TAG_W-1:0]    tag_out
);

    localparam int CMP_W = HANDLE_W + 2;

    logic               valid_reg;
    logic               token_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [ROT_W-1:0]   rot_reg;
    logic [TAG_W-1:0]   tag_reg;

    logic match;
    logic rot_zero;
    logic sel;

    assign match    = valid_reg && (slot_reg == cur_slot);
    assign rot_zero = (rot_reg == '0);
    assign sel      = ({{(CMP_W-HANDLE_W){1'b0}}, handle} == CMP_W'(IDX));

    // lowest free entry takes the new timer
    assign free_out        = free_in | ~valid_reg;
    assign stat.take       = ctrl.alloc && !valid_reg && !free_in;
    assign stat.hit        = token_reg && match && rot_zero && ctrl.room;
    assign stat.cancel_hit = sel && valid_reg;
    assign tag_out         = stat.hit ? tag_reg : '0;
    assign token_out       = token_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            token_reg <= 1'b0;
        end else begin
            if (ctrl.tok_load) begin
                token_reg <= (IDX == 0);
            end else if (ctrl.step) begin
                token_reg <= token_in;
            end
            if (stat.take) begin
                valid_reg <= 1'b1;
            end
            if (ctrl.cancel && stat.cancel_hit) begin
                valid_reg <= 1'b0;
            end
            if (ctrl.step && stat.hit) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.take) begin
            slot_reg <= new_slot;
            rot_reg  <= new_rot;
            tag_reg  <= new_tag;
        end else if (ctrl.step && token_reg && match && !rot_zero) begin
            rot_reg <= rot_reg - 1'b1;
        end
    end

endmodule

### hdl/hashed_timer_wheel_top.sv
// top level of the hashed timer wheel: request sequencer and cell chain
// depends on htw_pkg and htw_cell
//
// Hashed timing wheel over SLOTS slots holding TIMERS timer entries, one per
// cell of a chain. A register request (command 0) first finds timeout div
// SLOTS by a multiplication with a fixed rounded-up reciprocal, then timeout
// mod SLOTS from that quotient, one registered step each, and then stores the
// timer in the lowest free entry and answers, or answers with a failure if
// no entry is free. A cancel request is command 1. A tick (command 2) passes
// a token down the chain, one entry per cycle unless a new expiry must push
// the held one out while the output is busy; expiries come out in ascending
// handle order and the final result of a tick carries tlast.
// Command 3 is swallowed with no result. Requests are taken only
// while the sequencer is idle; a result waiting in the output register does
// not hold off the next request, and back-pressure on the result side only
// stalls the sequencer where a result has to be delivered: the answer of a
// register or cancel, each expiry after the first of a tick and its closing
// result.
module hashed_timer_wheel_top
    import htw_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int TIMERS = TIMERS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: timeout [15:0], handle [20:16], tag [36:21], zero [39:37]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: command [1:0]
    input  logic [CMD_W-1:0]     s_tuser,
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: timer_id [4:0], user_tag [20:5], zero [23:21]
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: kind [2:0]
    output logic [KIND_W-1:0]    m_tuser,
    output logic                 m_tlast
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ROT_W  = $clog2((65535 / SLOTS) + 1);
    localparam int IDX_W  = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CNT_W  = $clog2(MAX_OUT + 1);

    // rounded-up reciprocal of SLOTS, exact for every timeout value
    localparam int RCP_SHIFT = TIMEOUT_W + SLOT_W;
    localparam int RCP_W     = TIMEOUT_W + 1;
    localparam int PROD_W    = TIMEOUT_W + RCP_W;
    localparam logic [RCP_W-1:0]     RCP_VAL   =
        RCP_W'(((2 ** RCP_SHIFT) + SLOTS - 1) / SLOTS);
    localparam logic [TIMEOUT_W-1:0] SLOTS_VAL = TIMEOUT_W'(SLOTS);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_REG    = 3'd2;
    localparam logic [2:0] ST_CANCEL = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_FLUSH  = 3'd5;
    localparam logic [2:0] ST_REM    = 3'd6;

    logic [2:0] state_reg, state_next;

    // timeout div / mod SLOTS
    logic [TIMEOUT_W-1:0] dvd_reg, dvd_next;
    logic [TIMEOUT_W-1:0] quo_reg, quo_next;
    logic [SLOT_W-1:0]    rem_reg, rem_next;

    logic [HANDLE_W-1:0]  handle_reg, handle_next;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic [SLOT_W-1:0]    cur_slot_reg, cur_slot_next;

    // held-back expiry, so that tlast can go on the final one
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_id_reg, pend_id_next;
    logic [TAG_W-1:0]     pend_tag_reg, pend_tag_next;
    logic [CNT_W-1:0]     exp_cnt_reg, exp_cnt_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]    m_kind_reg, m_kind_next;
    logic [HANDLE_W-1:0]  m_id_reg, m_id_next;
    logic [TAG_W-1:0]     m_tag_reg, m_tag_next;
    logic                 m_last_reg, m_last_next;

    logic                 accept;
    logic                 out_free;
    htw_ctrl_t            ctrl;

    // request fields
    logic [TIMEOUT_W-1:0] in_timeout;
    logic [HANDLE_W-1:0]  in_handle;
    logic [TAG_W-1:0]     in_tag;

    // chain
    logic [TIMERS:0]      free_chain;
    logic [TIMERS:0]      tok_chain;
    htw_stat_t            stat_vec [TIMERS];
    logic [TAG_W-1:0]     tag_vec  [TIMERS];

    logic                 any_hit;
    logic                 any_cancel;
    logic [IDX_W-1:0]     hit_id;
    logic [IDX_W-1:0]     take_id;
    logic [TAG_W-1:0]     hit_tag;

    // division and slot arithmetic
    logic [PROD_W-1:0]    rcp_prod;
    logic [TIMEOUT_W-1:0] rem_full;
    logic [SLOT_W:0]      slot_sum;
    logic [SLOT_W-1:0]    new_slot;
    logic [ROT_W-1:0]     new_rot;

    assign in_timeout = s_tdata[15:0];
    assign in_handle  = s_tdata[20:16];
    assign in_tag     = s_tdata[36:21];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // quotient from the reciprocal, remainder from the quotient
    assign rcp_prod = {{RCP_W{1'b0}}, dvd_reg} * {{TIMEOUT_W{1'b0}}, RCP_VAL};
    assign rem_full = dvd_reg - (quo_reg * SLOTS_VAL);
    assign slot_sum = {1'b0, cur_slot_reg} + {1'b0, rem_reg};
    assign new_slot = (slot_sum >= (SLOT_W+1)'(SLOTS)) ?
                      SLOT_W'(slot_sum - (SLOT_W+1)'(SLOTS)) : slot_sum[SLOT_W-1:0];
    assign new_rot  = quo_reg[ROT_W-1:0];

    assign free_chain[0] = 1'b0;
    assign tok_chain[0]  = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < TIMERS; gi++) begin : g_cell
            htw_cell #(
                .IDX    (gi),
                .SLOT_W (SLOT_W),
                .ROT_W  (ROT_W)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .cur_slot  (cur_slot_reg),
                .new_slot  (new_slot),
                .new_rot   (new_rot),
                .new_tag   (tag_reg),
                .handle    (handle_reg),
                .free_in   (free_chain[gi]),
                .free_out  (free_chain[gi+1]),
                .token_in  (tok_chain[gi]),
                .token_out (tok_chain[gi+1]),
                .stat      (stat_vec[gi]),
                .tag_out   (tag_vec[gi])
            );
        end
    endgenerate

    // at most one cell holds the token and at most one takes a new timer
    always_comb begin
        any_hit    = 1'b0;
        any_cancel = 1'b0;
        hit_id     = '0;
        take_id    = '0;
        hit_tag    = '0;
        for (int i = 0; i < TIMERS; i++) begin
            any_hit    = any_hit | stat_vec[i].hit;
            any_cancel = any_cancel | stat_vec[i].cancel_hit;
            hit_tag    = hit_tag | tag_vec[i];
            if (stat_vec[i].hit) begin
                hit_id = hit_id | IDX_W'(i);
            end
            if (stat_vec[i].take) begin
                take_id = take_id | IDX_W'(i);
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        dvd_next        = dvd_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        handle_next     = handle_reg;
        tag_next        = tag_reg;
        cur_slot_next   = cur_slot_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_tag_next   = pend_tag_reg;
        exp_cnt_next    = exp_cnt_reg;

        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_id_next    = m_id_reg;
        m_tag_next   = m_tag_reg;
        m_last_next  = m_last_reg;

        ctrl.alloc    = 1'b0;
        ctrl.cancel   = 1'b0;
        ctrl.tok_load = 1'b0;
        ctrl.step     = 1'b0;
        ctrl.room     = (exp_cnt_reg < CNT_W'(MAX_OUT));

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        CMD_REGISTER: begin
                            dvd_next   = in_timeout;
                            quo_next   = '0;
                            rem_next   = '0;
                            tag_next   = in_tag;
                            state_next = ST_DIV;
                        end
                        CMD_CANCEL: begin
                            handle_next = in_handle;
                            state_next  = ST_CANCEL;
                        end
                        CMD_TICK: begin
                            ctrl.tok_load   = 1'b1;
                            pend_valid_next = 1'b0;
                            exp_cnt_next    = '0;
                            state_next      = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                quo_next   = TIMEOUT_W'(rcp_prod >> RCP_SHIFT);
                state_next = ST_REM;
            end
            ST_REM: begin
                rem_next   = rem_full[SLOT_W-1:0];
                state_next = ST_REG;
            end
            ST_REG: begin
                if (out_free) begin
                    ctrl.alloc   = 1'b1;
                    m_valid_next = 1'b1;
                    m_tag_next   = '0;
                    m_last_next  = 1'b1;
                    if (free_chain[TIMERS]) begin
                        m_kind_next = KIND_REGISTERED;
                        m_id_next   = HANDLE_W'(take_id);
                    end else begin
                        m_kind_next = KIND_REG_FAILED;
                        m_id_next   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_CANCEL: begin
                if (out_free) begin
                    ctrl.cancel  = 1'b1;
                    m_valid_next = 1'b1;
                    m_kind_next  = any_cancel ? KIND_CANCELLED : KIND_CANCEL_FAIL;
                    m_id_next    = handle_reg;
                    m_tag_next   = '0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // a new expiry pushes the held one out, which needs the output free
                ctrl.step = !any_hit || !pend_valid_reg || out_free;
                if (ctrl.step) begin
                    if (any_hit) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_EXPIRED;
                            m_id_next    = HANDLE_W'(pend_id_reg);
                            m_tag_next   = pend_tag_reg;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = hit_id;
                        pend_tag_next   = hit_tag;
                        exp_cnt_next    = exp_cnt_reg + 1'b1;
                    end
                    if (tok_chain[TIMERS]) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    if (pend_valid_reg) begin
                        m_kind_next = KIND_EXPIRED;
                        m_id_next   = HANDLE_W'(pend_id_reg);
                        m_tag_next  = pend_tag_reg;
                    end else begin
                        m_kind_next = KIND_TICK_NONE;
                        m_id_next   = '0;
                        m_tag_next  = '0;
                    end
                    pend_valid_next = 1'b0;
                    cur_slot_next   = (cur_slot_reg == SLOT_W'(SLOTS - 1)) ?
                                      '0 : cur_slot_reg + 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_slot_reg   <= '0;
            pend_valid_reg <= 1'b0;
            exp_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_slot_reg   <= cur_slot_next;
            pend_valid_reg <= pend_valid_next;
            exp_cnt_reg    <= exp_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        handle_reg   <= handle_next;
        tag_reg      <= tag_next;
        pend_id_reg  <= pend_id_next;
        pend_tag_reg <= pend_tag_next;
        m_kind_reg   <= m_kind_next;
        m_id_reg     <= m_id_next;
        m_tag_reg    <= m_tag_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W-HANDLE_W-TAG_W){1'b0}}, m_tag_reg, m_id_reg};

endmodule
